>>> rtl/crc32c_string_hash_fmix_assert.svh
// assertion macros for the crc32c string hash block
`ifndef CRC32C_STRING_HASH_FMIX_ASSERT_SVH
`define CRC32C_STRING_HASH_FMIX_ASSERT_SVH

`ifndef NO_ASSERTIONS

// condition must never hold
`define CHSF_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// same-cycle implication
`define CHSF_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CHSF_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define CHSF_NEVER(lbl, clk, rst, cond, msg)
`define CHSF_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define CHSF_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

>>> rtl/chsf_pkg.sv
// shared types, constants and crc helpers for the crc32c string hash
package chsf_pkg;

  localparam logic [31:0] CRC_POLY = 32'h82F63B78;
  localparam logic [31:0] FMIX_C1  = 32'h85ebca6b;
  localparam logic [31:0] FMIX_C2  = 32'hc2b2ae35;
  localparam int          FMIX_SH_A = 16;
  localparam int          FMIX_SH_B = 13;

  localparam int SHORT_BYTES = 4;
  localparam int BLOCK_BYTES = 16;
  localparam int QUEUE_DEPTH = 2;

  typedef logic [31:0] crc_tbl_t [256];

  function automatic crc_tbl_t crc_tbl_gen();
    crc_tbl_t    t;
    logic [31:0] c;
    for (int i = 0; i < 256; i++) begin
      c = 32'(i);
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      t[i] = c;
    end
    return t;
  endfunction

  localparam crc_tbl_t CRC_TBL = crc_tbl_gen();

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [7:0] idx;
    idx = crc[7:0] ^ b;
    return (crc >> 8) ^ CRC_TBL[idx];
  endfunction

  // one classified item: up to four bytes, first in data[7:0] unless fold
  typedef struct packed {
    logic        init;
    logic [15:0] len;
    logic        to_block;
    logic        fold;
    logic [2:0]  nbytes;
    logic [31:0] data;
    logic        last;
  } chsf_entry_t;

  typedef struct packed {
    logic second;
    logic fin_pending;
  } chsf_back_stat_t;

endpackage

>>> rtl/crc32c_string_hash_fmix.sv
// top level of the crc32c string hash with fmix32 finalizer
// Code units enter through a queue-style port and are taken one per cycle
// while the two-entry item queue has room. The crc unit absorbs one item per
// cycle unless a hash waits for the finalizer, two byte steps chained through
// the crc32c table; items needing three or four byte steps (the block fold,
// the trailing unit of a string under 16 bytes) get a second pass. On a last
// item the crc unit waits until the finalizer takes the accumulator, at the
// earliest in the cycle after that item leaves the queue. The taking edge
// loads the first multiply stage; the hash then passes the second multiply
// stage, then the output stage, the result register, where it stays until popped.
`include "crc32c_string_hash_fmix_assert.svh"

module crc32c_string_hash_fmix import chsf_pkg::*; #(
  parameter int MAX_CHARS = 65535
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [15:0] code_unit,
  input  logic [15:0] char_count,
  input  logic        first_item,
  input  logic        last_item,
  input  logic        pop,
  output logic        empty,
  output logic [31:0] hash_value
);

  chsf_entry_t     f_entry, q_head;
  logic            q_push, q_pop, q_full, q_empty;
  logic            fin_valid, fin_ready;
  logic [31:0]     fin_crc;
  chsf_back_stat_t bstat;
  logic            head_long, fin_take;

  assign q_push = push && !q_full;
  assign full   = q_full;

  chsf_front #(
    .MAX_CHARS(MAX_CHARS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (q_push),
    .code_unit  (code_unit),
    .char_count (char_count),
    .first_item (first_item),
    .last_item  (last_item),
    .entry      (f_entry)
  );

  chsf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_entry (f_entry),
    .rd_en    (q_pop),
    .rd_entry (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  chsf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (!q_empty),
    .q_entry   (q_head),
    .q_pop     (q_pop),
    .fin_valid (fin_valid),
    .fin_ready (fin_ready),
    .fin_crc   (fin_crc),
    .stat      (bstat)
  );

  chsf_fmix u_fmix (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (fin_valid),
    .in_ready   (fin_ready),
    .in_hash    (fin_crc),
    .pop        (pop),
    .empty      (empty),
    .hash_value (hash_value)
  );

  assign head_long = !q_empty && (q_head.nbytes > 3'd2);
  assign fin_take  = fin_valid && fin_ready;

  `CHSF_NEVER(a_pop_while_fin, clk, rst, bstat.fin_pending && q_pop, "crc pop while hash pending")
  `CHSF_IMPLIES(a_second_step, clk, rst, bstat.second, head_long, "second cycle on short item")
  `CHSF_NEXT(a_fin_handoff, clk, rst, fin_take, !bstat.fin_pending, "pending kept after handoff")
  `CHSF_NEVER(a_fin_no_queue_pop, clk, rst, q_pop && q_empty, "item queue popped while empty")

endmodule

>>> rtl/chsf_front.sv
// front end: tracks string position and classifies each item into crc work
module chsf_front import chsf_pkg::*; #(
  parameter int MAX_CHARS = 65535
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [15:0] code_unit,
  input  logic [15:0] char_count,
  input  logic        first_item,
  input  logic        last_item,
  output chsf_entry_t entry
);

  logic [16:0] byte_position, byte_position_next;
  logic [16:0] size_latch, size_latch_next;
  logic [15:0] len;
  logic [16:0] s, p, sm1, blocks_end, words_end, mid_words_end;
  logic [7:0]  lo, hi;

  always_comb begin
    len = ({16'd0, char_count} > 32'(MAX_CHARS)) ? 16'(MAX_CHARS) : char_count;
    s   = first_item ? {len, 1'b0} : size_latch;
    p   = first_item ? 17'd0 : byte_position;
    sm1 = s - 17'd1;
    blocks_end    = {sm1[16:4], 4'd0};
    words_end     = {sm1[16:2], 2'd0};
    mid_words_end = {s[16:2], 2'd0};
    lo = code_unit[7:0];
    hi = code_unit[15:8];

    entry          = '0;
    entry.init     = first_item;
    entry.len      = len;
    entry.last     = last_item;
    byte_position_next = p;
    size_latch_next    = s;

    if (p < s) begin
      byte_position_next = p + 17'd2;
      if (s < 17'(SHORT_BYTES)) begin
        entry.nbytes = 3'd2;
        entry.data   = {24'd0, lo};
      end else if (s < 17'(BLOCK_BYTES)) begin
        if (p < mid_words_end) begin
          entry.nbytes = 3'd2;
          entry.data   = {16'd0, hi, lo};
        end else begin
          entry.nbytes = 3'd4;
          entry.data   = {8'd0, hi, 8'd0, lo};
        end
      end else if (p < blocks_end) begin
        entry.to_block = 1'b1;
        entry.nbytes   = 3'd2;
        entry.data     = {16'd0, hi, lo};
      end else if (p == blocks_end) begin
        // fold in block accumulator low byte and a zero byte first
        entry.fold = 1'b1;
        if (p < words_end) begin
          entry.nbytes = 3'd4;
          entry.data   = {hi, lo, 16'd0};
        end else begin
          entry.nbytes = 3'd3;
          entry.data   = {8'd0, lo, 16'd0};
        end
      end else if (p < words_end) begin
        entry.nbytes = 3'd2;
        entry.data   = {16'd0, hi, lo};
      end else begin
        entry.nbytes = 3'd1;
        entry.data   = {24'd0, lo};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      size_latch    <= '0;
    end else if (accept) begin
      byte_position <= byte_position_next;
      size_latch    <= size_latch_next;
    end
  end

endmodule

>>> rtl/chsf_queue.sv
// small fifo of classified items between front and back
module chsf_queue import chsf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  chsf_entry_t wr_entry,
  input  logic        rd_en,
  output chsf_entry_t rd_entry,
  output logic        full,
  output logic        empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  chsf_entry_t      slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/chsf_back.sv
// back end: crc32c accumulators, up to two byte steps per cycle while no hash waits for the finalizer
module chsf_back import chsf_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  chsf_entry_t     q_entry,
  output logic            q_pop,
  output logic            fin_valid,
  input  logic            fin_ready,
  output logic [31:0]     fin_crc,
  output chsf_back_stat_t stat
);

  logic [31:0] main_crc, main_crc_next;
  logic [31:0] block_crc, block_crc_next;
  logic        second, second_next;
  logic        fin_pending, fin_pending_next;
  logic        use_init, go, done, two;
  logic [31:0] base_main, base_block, crc_in, crc_a, crc_b;
  logic [7:0]  b_a, b_b;

  always_comb begin
    use_init   = q_entry.init && !second;
    base_main  = use_init ? {16'd0, q_entry.len} : main_crc;
    base_block = use_init ? {15'd0, q_entry.len, 1'b0} : block_crc;
    if (!second) begin
      b_a  = q_entry.fold ? base_block[7:0] : q_entry.data[7:0];
      b_b  = q_entry.data[15:8];
      two  = (q_entry.nbytes >= 3'd2);
      done = (q_entry.nbytes <= 3'd2);
    end else begin
      b_a  = q_entry.data[23:16];
      b_b  = q_entry.data[31:24];
      two  = (q_entry.nbytes == 3'd4);
      done = 1'b1;
    end
    crc_in = q_entry.to_block ? base_block : base_main;
    crc_a  = crc_byte(crc_in, b_a);
    crc_b  = two ? crc_byte(crc_a, b_b) : crc_a;

    go               = q_valid && !fin_pending;
    q_pop            = 1'b0;
    main_crc_next    = main_crc;
    block_crc_next   = block_crc;
    second_next      = second;
    fin_pending_next = fin_pending;

    if (fin_pending && fin_ready) begin
      fin_pending_next = 1'b0;
    end
    if (go) begin
      main_crc_next  = base_main;
      block_crc_next = base_block;
      if (q_entry.nbytes != 3'd0) begin
        if (q_entry.to_block) begin
          block_crc_next = crc_b;
        end else begin
          main_crc_next = crc_b;
        end
      end
      if (done) begin
        second_next = 1'b0;
        q_pop       = 1'b1;
        if (q_entry.last) begin
          fin_pending_next = 1'b1;
        end
      end else begin
        second_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      main_crc    <= '0;
      block_crc   <= '0;
      second      <= 1'b0;
      fin_pending <= 1'b0;
    end else begin
      main_crc    <= main_crc_next;
      block_crc   <= block_crc_next;
      second      <= second_next;
      fin_pending <= fin_pending_next;
    end
  end

  assign fin_valid        = fin_pending;
  assign fin_crc          = main_crc;
  assign stat.second      = second;
  assign stat.fin_pending = fin_pending;

endmodule

>>> rtl/chsf_fmix.sv
// murmur3 fmix32 finalizer pipeline with one-entry result register
module chsf_fmix import chsf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_hash,
  input  logic        pop,
  output logic        empty,
  output logic [31:0] hash_value
);

  logic        v1, v2, vo;
  logic [31:0] r1, r2, ro;
  logic [31:0] x1, x2, p1, p2;
  logic        ready_o, adv2, ready2, adv1;

  always_comb begin
    ready_o  = !vo || pop;
    adv2     = v2 && ready_o;
    ready2   = !v2 || adv2;
    adv1     = v1 && ready2;
    in_ready = !v1 || adv1;
    x1 = in_hash ^ (in_hash >> FMIX_SH_A);
    p1 = x1 * FMIX_C1;
    x2 = r1 ^ (r1 >> FMIX_SH_B);
    p2 = x2 * FMIX_C2;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      r1 <= p1;
    end
    if (adv1) begin
      r2 <= p2;
    end
    if (adv2) begin
      ro <= r2 ^ (r2 >> FMIX_SH_A);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (in_ready) begin
        v1 <= in_valid;
      end
      if (ready2) begin
        v2 <= adv1;
      end
      if (ready_o) begin
        vo <= adv2;
      end
    end
  end

  assign empty      = !vo;
  assign hash_value = ro;

endmodule

>>> sim/chsf_hash_checker.sv
// checker for the crc32c string hash: predicts each hash and compares popped results
module chsf_hash_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [15:0] code_unit,
  input  logic [15:0] char_count,
  input  logic        first_item,
  input  logic        last_item,
  input  logic        pop,
  input  logic        empty,
  input  logic [31:0] hash_value,
  output int          fail_count,
  output int          pending,
  output int          hashes_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] POLY_REFLECTED = 32'h82F63B78;
  localparam logic [31:0] MIX_MUL_A = 32'h85ebca6b;
  localparam logic [31:0] MIX_MUL_B = 32'hc2b2ae35;

  logic [31:0] main_acc;
  logic [31:0] block_acc;
  logic [16:0] bytes_done;
  logic [16:0] byte_size;
  logic [31:0] expected_hashes[$];

  function automatic logic [31:0] crc32c_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ POLY_REFLECTED) : (r >> 1);
    end
    return r;
  endfunction

  function automatic logic [31:0] fmix32(input logic [31:0] h);
    logic [31:0] r;
    r = h ^ (h >> 16);
    r = r * MIX_MUL_A;
    r = r ^ (r >> 13);
    r = r * MIX_MUL_B;
    r = r ^ (r >> 16);
    return r;
  endfunction

  function automatic void absorb_unit(input logic [15:0] cu, input logic [15:0] cnt,
                                      input logic first_flag, input logic last_flag);
    logic [7:0] lo;
    logic [7:0] hi;
    int p;
    int s;
    int blocks_end;
    int words_end;
    lo = cu[7:0];
    hi = cu[15:8];
    // count is 16 bits wide, so it never exceeds the saturation limit
    if (first_flag) begin
      byte_size = {cnt, 1'b0};
      main_acc = {16'h0, cnt};
      block_acc = {15'h0, byte_size};
      bytes_done = '0;
    end
    p = bytes_done;
    s = byte_size;
    if (p < s) begin
      if (s < 4) begin
        main_acc = crc32c_step(crc32c_step(main_acc, lo), 8'h00);
      end else if (s < 16) begin
        if (p < (s & ~3)) begin
          main_acc = crc32c_step(crc32c_step(main_acc, lo), hi);
        end else begin
          // lone trailing unit, zero padded per byte
          main_acc = crc32c_step(crc32c_step(main_acc, lo), 8'h00);
          main_acc = crc32c_step(crc32c_step(main_acc, hi), 8'h00);
        end
      end else begin
        blocks_end = 16 * ((s - 1) / 16);
        if (p < blocks_end) begin
          block_acc = crc32c_step(crc32c_step(block_acc, lo), hi);
        end else begin
          words_end = blocks_end + 4 * ((s - blocks_end - 1) / 4);
          // fold: low byte of the block accumulator, then bits 39:32 which are zero
          if (p == blocks_end) begin
            main_acc = crc32c_step(main_acc, block_acc[7:0]);
            main_acc = crc32c_step(main_acc, 8'h00);
          end
          if (p < words_end) begin
            main_acc = crc32c_step(crc32c_step(main_acc, lo), hi);
          end else begin
            main_acc = crc32c_step(main_acc, lo);
          end
        end
      end
      bytes_done = 17'(p + 2);
    end
    if (last_flag) begin
      expected_hashes.push_back(fmix32(main_acc));
    end
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
    hashes_checked = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      main_acc = '0;
      block_acc = '0;
      bytes_done = '0;
      byte_size = '0;
      expected_hashes.delete();
    end else begin
      if (pop && !empty) begin
        if (expected_hashes.size() == 0) begin
          $error("hash_value: no result expected, actual %h", hash_value);
          fail_count <= fail_count + 1;
        end else begin
          if (hash_value !== expected_hashes[0]) begin
            $error("hash_value mismatch: expected %h, actual %h",
                   expected_hashes[0], hash_value);
            fail_count <= fail_count + 1;
          end
          void'(expected_hashes.pop_front());
          hashes_checked <= hashes_checked + 1;
        end
      end
      if (push && !full) begin
        absorb_unit(code_unit, char_count, first_item, last_item);
      end
    end
    pending <= expected_hashes.size();
  end

endmodule

>>> sim/testbench.sv
// top of the crc32c string hash testbench: clock, reset, stimulus, pacing and verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 4000;
  localparam int BEATS_PER_PHASE = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [15:0] code_unit = '0;
  logic [15:0] char_count = '0;
  logic        first_item = 1'b0;
  logic        last_item = 1'b0;
  logic        pop = 1'b0;
  logic        empty;
  logic [31:0] hash_value;

  int fail_count;
  int pending;
  int hashes_checked;
  int send_idle_pct = 11;
  int pop_idle_pct = 61;
  int beats_sent = 0;
  int strings_sent = 0;
  int quiet_cycles = 0;

  crc32c_string_hash_fmix dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .code_unit(code_unit),
    .char_count(char_count),
    .first_item(first_item),
    .last_item(last_item),
    .pop(pop),
    .empty(empty),
    .hash_value(hash_value)
  );

  chsf_hash_checker hash_check (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .code_unit(code_unit),
    .char_count(char_count),
    .first_item(first_item),
    .last_item(last_item),
    .pop(pop),
    .empty(empty),
    .hash_value(hash_value),
    .fail_count(fail_count),
    .pending(pending),
    .hashes_checked(hashes_checked)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    pop <= ($urandom_range(0, 99) >= pop_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_beat(input logic [15:0] cu, input logic [15:0] cnt,
                           input logic first_flag, input logic last_flag);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    code_unit <= cu;
    char_count <= cnt;
    first_item <= first_flag;
    last_item <= last_flag;
    @(posedge clk);
    while (full) @(posedge clk);
    beats_sent++;
  endtask

  // n_beats beats, first carries cnt, last closes the string
  task automatic send_string(input logic [15:0] cnt, input int n_beats, input bit extremes);
    logic [15:0] cu;
    strings_sent++;
    for (int i = 0; i < n_beats; i++) begin
      cu = extremes ? ((i % 2 == 0) ? 16'hFFFF : 16'h0000) : 16'($urandom);
      send_beat(cu, cnt, i == 0, i == n_beats - 1);
    end
  endtask

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 40);
    if (r < 97) return $urandom_range(41, 130);
    return $urandom_range(131, 600);
  endfunction

  task automatic send_random_string();
    int sel;
    int n;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      n = pick_length();
      send_string(16'(n), (n == 0) ? 1 : n, 1'b0);
    end else if (sel < 80) begin
      // early last beat on a random count
      send_string(16'($urandom), $urandom_range(1, 8), 1'b0);
    end else if (sel < 90) begin
      n = pick_length();
      send_string(16'(n), (n == 0) ? 1 : n, 1'b0);
      repeat ($urandom_range(1, 3)) begin
        send_beat(16'($urandom), 16'($urandom), 1'b0, 1'($urandom_range(0, 1)));
      end
    end else begin
      repeat ($urandom_range(1, 4)) begin
        send_beat(16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // stray beat right after reset: nothing latched, hash of zero
    send_beat(16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
    send_string(16'd0, 1, 1'b1);
    send_string(16'd1, 1, 1'b1);
    send_string(16'd2, 2, 1'b1);
    send_string(16'd3, 3, 1'b1);
    send_string(16'd7, 7, 1'b1);
    send_string(16'd8, 8, 1'b1);
    send_string(16'hFFFF, 1, 1'b1);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 11;
          pop_idle_pct = 61;
        end
        1: begin
          send_idle_pct = 61;
          pop_idle_pct = 11;
        end
        default: begin
          send_idle_pct = 0;
          pop_idle_pct = 0;
        end
      endcase
      while (beats_sent < (phase + 1) * BEATS_PER_PHASE) send_random_string();
      drain();
    end

    repeat (20) @(posedge clk);
    $display("covered %0d strings in %0d beats, %0d hashes compared", strings_sent,
             beats_sent, hashes_checked);
    $display("pacing: slow receiver, slow sender, then back to back");
    if (fail_count == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
